/* rtl/core/lc3_core_execute_macros.svh */
// Assertion macros for the core RTL.
`ifndef LC3_CORE_EXECUTE_MACROS_SVH
`define LC3_CORE_EXECUTE_MACROS_SVH

// Implication checked on the same edge.
`define LC3X_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked on the next edge.
`define LC3X_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/lc3x_pkg.sv */
// Shared constants, codes and helper functions of the LC-3 execute core.
package lc3x_pkg;

	localparam logic [15:0] USER_LOW   = 16'h3000;
	localparam logic [15:0] USER_END   = 16'hFE00;
	localparam logic [15:0] KB_STATUS  = 16'hFE00;
	localparam logic [15:0] INT_VECTOR = 16'h0180;
	localparam logic [15:0] START_PC   = 16'h0200;
	localparam logic [15:0] KB_CLEAR   = 16'h7FFF;
	localparam int          MEM_DEPTH  = 65536;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_EXEC  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		OP_BR   = 4'd0,
		OP_ADD  = 4'd1,
		OP_LD   = 4'd2,
		OP_ST   = 4'd3,
		OP_JSR  = 4'd4,
		OP_AND  = 4'd5,
		OP_LDR  = 4'd6,
		OP_STR  = 4'd7,
		OP_RTI  = 4'd8,
		OP_NOT  = 4'd9,
		OP_LDI  = 4'd10,
		OP_STI  = 4'd11,
		OP_JMP  = 4'd12,
		OP_RES  = 4'd13,
		OP_LEA  = 4'd14,
		OP_TRAP = 4'd15
	} opcode_t;

	function automatic logic [15:0] sext5(input logic [4:0] v);
		return {{11{v[4]}}, v};
	endfunction

	function automatic logic [15:0] sext6(input logic [5:0] v);
		return {{10{v[5]}}, v};
	endfunction

	function automatic logic [15:0] sext9(input logic [8:0] v);
		return {{7{v[8]}}, v};
	endfunction

	function automatic logic [15:0] sext11(input logic [10:0] v);
		return {{5{v[10]}}, v};
	endfunction

	// user-mode access outside the allowed window
	function automatic logic addr_bad(input logic user, input logic [15:0] a);
		return user && ((a < USER_LOW) || (a >= USER_END));
	endfunction

	function automatic logic [2:0] flags_of(input logic [15:0] v);
		return v[15] ? 3'b100 : ((v == 16'h0000) ? 3'b010 : 3'b001);
	endfunction

endpackage

/* rtl/core/lc3x_ram.sv */
// Generic single-port RAM with registered read data.
module lc3x_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

/* rtl/core/lc3_core_execute.sv */
// Top level of the LC-3 execute core: sequencer around one word memory.
// Write and read requests go straight to the result register load; execute steps through the
// sequencer states (none when the core is frozen), all serialised on the one memory port.
// A new request is taken the cycle after its result is loaded; a stalled result holds the core.
// Reset: state clears at once; then a clearing pass writes zero to all 65536 words, during
// which no request is accepted.
module lc3_core_execute (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // address[15:0], write_data[31:16]
	input  logic [1:0]  s_tuser,  // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // read_data[15:0], pc_after[31:16], cond_codes[34:32],
	                              // user_mode[35], access_violation[36],
	                              // interrupt_taken[37], zero fill[39:38]
);
	import lc3x_pkg::*;
	`include "lc3_core_execute_macros.svh"

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RDWAIT, S_KB, S_PUSH1, S_PUSH2, S_VECRD, S_VEC,
		S_FETCH, S_DEC, S_OP1, S_EXEC, S_LDW, S_INDW, S_RTI1, S_RTI2
	} state_t;

	state_t      state_q;
	logic [15:0] clr_q;
	logic [15:0] pc_q, psr_q, ssp_q, usp_q, sp_q;
	logic        frozen_q, took_q, ind_q;
	logic [15:0] regs_q [8];
	logic [15:0] ir_q, b_q, opnd_q, rd_q;
	logic [39:0] out_q;
	logic        out_valid_q;

	logic        mem_en, mem_we;
	logic [15:0] mem_addr, mem_wd, mem_rd;
	logic [2:0]  rf_idx;
	logic [15:0] rf_rd;
	opcode_t     op;
	logic [2:0]  fd, fs2;
	logic [15:0] ea, sp_new;
	logic        kb_take, is_ld, is_st, accept, exec_more;

	assign op     = opcode_t'(ir_q[15:12]);
	assign fd     = ir_q[11:9];
	assign fs2    = ir_q[2:0];
	assign ea     = (op == OP_LDR || op == OP_STR) ? b_q + sext6(ir_q[5:0])
	                                               : pc_q + sext9(ir_q[8:0]);
	assign is_ld  = (op == OP_LD) || (op == OP_LDI) || (op == OP_LDR);
	assign is_st  = (op == OP_ST) || (op == OP_STI) || (op == OP_STR);
	// instruction continues past the execute state
	assign exec_more = (op == OP_TRAP) || (op == OP_RTI) ||
	                   ((is_ld || op == OP_STI) && !addr_bad(psr_q[15], ea));
	assign kb_take = mem_rd[15] && mem_rd[14] && !psr_q[10];
	assign sp_new = psr_q[15] ? ssp_q : rf_rd;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
	assign rf_rd    = regs_q[rf_idx];

	always_comb begin
		case (state_q)
			S_DEC:   rf_idx = mem_rd[8:6];
			S_OP1:   rf_idx = is_st ? fd : fs2;
			default: rf_idx = 3'd6;
		endcase
	end

	always_comb begin
		mem_en   = 1'b0;
		mem_we   = 1'b0;
		mem_addr = clr_q;
		mem_wd   = 16'h0000;
		case (state_q)
			S_CLEAR: begin
				mem_en = 1'b1;
				mem_we = 1'b1;
			end
			S_IDLE: begin
				if (accept) begin
					case (action_t'(s_tuser))
						ACT_WRITE: begin
							mem_en   = 1'b1;
							mem_we   = 1'b1;
							mem_addr = s_tdata[15:0];
							mem_wd   = s_tdata[31:16];
						end
						ACT_READ: begin
							mem_en   = 1'b1;
							mem_addr = s_tdata[15:0];
						end
						ACT_EXEC: begin
							mem_en   = !frozen_q;
							mem_addr = KB_STATUS;
						end
						default: ;
					endcase
				end
			end
			S_KB: begin
				mem_en   = kb_take;
				mem_we   = kb_take;
				mem_addr = KB_STATUS;
				mem_wd   = mem_rd & KB_CLEAR;
			end
			S_PUSH1: begin
				mem_en   = 1'b1;
				mem_we   = 1'b1;
				mem_addr = sp_q - 16'd1;
				mem_wd   = psr_q;
			end
			S_PUSH2: begin
				mem_en   = 1'b1;
				mem_we   = 1'b1;
				mem_addr = sp_q - 16'd2;
				mem_wd   = pc_q;
			end
			S_VECRD: begin
				mem_en   = 1'b1;
				mem_addr = ind_q ? {8'h00, ir_q[7:0]} : INT_VECTOR;
			end
			S_FETCH: begin
				mem_en   = !addr_bad(psr_q[15], pc_q);
				mem_addr = pc_q;
			end
			S_EXEC: begin
				if (op == OP_RTI) begin
					mem_en   = 1'b1;
					mem_addr = rf_rd;
				end else if ((is_ld || is_st) && !addr_bad(psr_q[15], ea)) begin
					mem_en   = 1'b1;
					mem_we   = (op == OP_ST) || (op == OP_STR);
					mem_addr = ea;
					mem_wd   = opnd_q;
				end
			end
			S_LDW: begin
				mem_en   = ind_q && !addr_bad(psr_q[15], mem_rd);
				mem_addr = mem_rd;
			end
			S_INDW: begin
				mem_en   = !addr_bad(psr_q[15], mem_rd);
				mem_we   = mem_en;
				mem_addr = mem_rd;
				mem_wd   = opnd_q;
			end
			S_RTI1: begin
				mem_en   = 1'b1;
				mem_addr = sp_q + 16'd1;
			end
			default: ;
		endcase
	end

	lc3x_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_mem (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wd),
		.rdata (mem_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= 16'h0000;
			pc_q        <= START_PC;
			psr_q       <= 16'h0000;
			ssp_q       <= USER_LOW;
			usp_q       <= USER_END;
			frozen_q    <= 1'b0;
			took_q      <= 1'b0;
			ind_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				regs_q[i] <= 16'h0000;
			end
		end else begin
			if (out_valid_q && m_tready && state_q != S_RDWAIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 16'd1;
					if (clr_q == 16'hFFFF) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						rd_q   <= 16'h0000;
						took_q <= 1'b0;
						// requests that finish at once report through the same path
						case (action_t'(s_tuser))
							ACT_READ: begin
								state_q <= S_RDWAIT;
								ind_q   <= 1'b0;
							end
							ACT_EXEC: begin
								state_q <= frozen_q ? S_RDWAIT : S_KB;
								ind_q   <= frozen_q;
							end
							default: begin
								state_q <= S_RDWAIT;
								ind_q   <= 1'b1;
							end
						endcase
					end
				end
				S_RDWAIT: begin
					// ind_q marks a request with no memory read to capture
					if (!out_valid_q || m_tready) begin
						out_q       <= {2'b00, took_q, frozen_q, psr_q[15], psr_q[2:0], pc_q,
						                ind_q ? rd_q : mem_rd};
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (!ind_q) begin
						rd_q  <= mem_rd;
						ind_q <= 1'b1;
					end
				end
				S_KB: begin
					if (kb_take) begin
						took_q  <= 1'b1;
						sp_q    <= sp_new;
						state_q <= S_PUSH1;
						if (psr_q[15]) begin
							usp_q <= rf_rd;
						end
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_PUSH1: state_q <= S_PUSH2;
				S_PUSH2: begin
					regs_q[6]  <= sp_q - 16'd2;
					psr_q[15]  <= 1'b0;
					// interrupt entry raises the level; a trap keeps it
					if (!ind_q) begin
						psr_q[10:8] <= 3'd4;
					end
					state_q <= S_VECRD;
				end
				S_VECRD: state_q <= S_VEC;
				S_VEC: begin
					pc_q <= mem_rd;
					if (ind_q) begin
						state_q <= S_RDWAIT;
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					if (addr_bad(psr_q[15], pc_q)) begin
						frozen_q <= 1'b1;
						ind_q    <= 1'b1;
						state_q  <= S_RDWAIT;
					end else begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					ir_q    <= mem_rd;
					pc_q    <= pc_q + 16'd1;
					b_q     <= rf_rd;
					state_q <= S_OP1;
				end
				S_OP1: begin
					opnd_q  <= (!is_st && ir_q[5]) ? sext5(ir_q[4:0]) : rf_rd;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (!exec_more) begin
						state_q <= S_RDWAIT;
						ind_q   <= 1'b1;
					end
					case (op)
						OP_ADD: begin
							regs_q[fd] <= b_q + opnd_q;
							psr_q[2:0] <= flags_of(b_q + opnd_q);
						end
						OP_AND: begin
							regs_q[fd] <= b_q & opnd_q;
							psr_q[2:0] <= flags_of(b_q & opnd_q);
						end
						OP_NOT: begin
							regs_q[fd] <= ~b_q;
							psr_q[2:0] <= flags_of(~b_q);
						end
						OP_BR: begin
							if ((ir_q[11:9] & psr_q[2:0]) != 3'b000) begin
								pc_q <= pc_q + sext9(ir_q[8:0]);
							end
						end
						OP_JMP: pc_q <= b_q;
						OP_JSR: begin
							regs_q[7] <= pc_q;
							pc_q      <= ir_q[11] ? pc_q + sext11(ir_q[10:0]) : b_q;
						end
						OP_LEA: regs_q[fd] <= pc_q + sext9(ir_q[8:0]);
						OP_LD, OP_LDR, OP_LDI, OP_ST, OP_STR, OP_STI: begin
							if (addr_bad(psr_q[15], ea)) begin
								frozen_q <= 1'b1;
							end else if (is_ld) begin
								ind_q   <= (op == OP_LDI);
								state_q <= S_LDW;
							end else if (op == OP_STI) begin
								state_q <= S_INDW;
							end
						end
						OP_TRAP: begin
							sp_q    <= sp_new;
							ind_q   <= 1'b1;
							state_q <= S_PUSH1;
							if (psr_q[15]) begin
								usp_q <= rf_rd;
							end
						end
						OP_RTI: begin
							sp_q    <= rf_rd;
							state_q <= S_RTI1;
						end
						default: ;
					endcase
				end
				S_LDW: begin
					if (ind_q) begin
						if (addr_bad(psr_q[15], mem_rd)) begin
							frozen_q <= 1'b1;
							state_q  <= S_RDWAIT;
						end else begin
							ind_q <= 1'b0;
						end
					end else begin
						regs_q[fd] <= mem_rd;
						psr_q[2:0] <= flags_of(mem_rd);
						ind_q      <= 1'b1;
						state_q    <= S_RDWAIT;
					end
				end
				S_INDW: begin
					if (addr_bad(psr_q[15], mem_rd)) begin
						frozen_q <= 1'b1;
					end
					ind_q   <= 1'b1;
					state_q <= S_RDWAIT;
				end
				S_RTI1: begin
					pc_q    <= mem_rd;
					state_q <= S_RTI2;
				end
				S_RTI2: begin
					psr_q <= mem_rd;
					if (mem_rd[15]) begin
						ssp_q     <= sp_q + 16'd2;
						regs_q[6] <= usp_q;
					end else begin
						regs_q[6] <= sp_q + 16'd2;
					end
					ind_q   <= 1'b1;
					state_q <= S_RDWAIT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`LC3X_ASSERT_NOW(a_no_accept_clear, state_q == S_CLEAR, !s_tready, "request accepted during clear")
	`LC3X_ASSERT_NEXT(a_frozen_sticks, frozen_q, frozen_q, "frozen flag dropped")
	`LC3X_ASSERT_NOW(a_user_no_fetch, state_q == S_FETCH && addr_bad(psr_q[15], pc_q), !mem_en, "fetch outside user window")

endmodule
